@@ rtl/tsu_pkg.sv @@
// Shared types and constants for the multi-slot tick timeout unit.
package tsu_pkg;

  localparam int SLOTS   = 32;
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int COUNT_W = 33;
  localparam int TIME_W  = 64;
  localparam int MASK_W  = 32;
  localparam int INDEX_W = 5;

  localparam logic [INDEX_W:0]    SLOT_LIMIT = (INDEX_W + 1)'(SLOTS);
  localparam logic [SLOT_W-1:0]   SLOT_TOP   = SLOT_W'(SLOTS - 1);

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_ARM   = 2'd1,
    MODE_DELAY = 2'd2,
    MODE_CLOCK = 2'd3
  } tsu_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_WALK_END,
    ST_SCAN,
    ST_OUT_WAIT
  } tsu_state_t;

  // controller -> datapath
  typedef struct packed {
    logic in_ready;
    logic walk_issue;
    logic idx_reload;
    logic scan_step;
    logic load_result;
  } tsu_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_valid;
    logic in_tick;
    logic idx_zero;
    logic exp_none;
    logic exp_hit;
    logic out_taken;
  } tsu_status_t;

endpackage

@@ rtl/tsu_ctrl.sv @@
// Sequencer for the timeout unit: accept, slot walk, expiry scan, result handoff.
module tsu_ctrl
  import tsu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  tsu_status_t status,
  output tsu_cmd_t    cmd
);

  tsu_state_t state;
  tsu_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (status.in_valid) begin
          state_next = status.in_tick ? ST_WALK : ST_SCAN;
        end
      end
      ST_WALK: begin
        if (status.idx_zero) begin
          state_next = ST_WALK_END;
        end
      end
      ST_WALK_END: begin
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.exp_none || status.exp_hit) begin
          state_next = ST_OUT_WAIT;
        end
      end
      ST_OUT_WAIT: begin
        if (status.out_taken) begin
          state_next = status.exp_none ? ST_IDLE : ST_SCAN;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE:     cmd.in_ready   = 1'b1;
      ST_WALK:     cmd.walk_issue = 1'b1;
      ST_WALK_END: cmd.idx_reload = 1'b1;
      ST_SCAN: begin
        cmd.load_result = status.exp_none || status.exp_hit;
        cmd.scan_step   = !(status.exp_none || status.exp_hit);
      end
      ST_OUT_WAIT: cmd = '0;
      default:     cmd = '0;
    endcase
  end

endmodule

@@ rtl/tsu_datapath.sv @@
// Datapath: tick and delay counters, slot count memory, shared decrementer, result register.
module tsu_datapath
  import tsu_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  tsu_cmd_t            cmd,
  output tsu_status_t         status,
  input  logic                in_valid,
  input  logic [1:0]          mode,
  input  logic [INDEX_W-1:0]  slot_index,
  input  logic [31:0]         count_value,
  input  logic                arm_enable,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                expired,
  output logic [INDEX_W-1:0]  expired_slot,
  output logic                last,
  output logic [TIME_W-1:0]   time_now,
  output logic                delay_busy,
  output logic [MASK_W-1:0]   active_slots
);

  logic [TIME_W-1:0]  tick_count;
  logic [SLOTS-1:0]   active_mask;
  logic [SLOTS-1:0]   exp_mask;
  logic [COUNT_W-1:0] delay_count;
  logic [SLOT_W-1:0]  idx;

  logic [COUNT_W-1:0] slot_mem [SLOTS];
  logic [COUNT_W-1:0] rd_data;

  logic               stg_valid;
  logic               stg_act;
  logic [SLOT_W-1:0]  stg_idx;

  logic               accept;
  logic               arm_ok;
  logic [COUNT_W-1:0] load_count;
  logic [COUNT_W-1:0] dec_count;
  logic               stg_update;
  logic               stg_expire;
  logic               mem_we;
  logic [SLOT_W-1:0]  mem_wa;
  logic [COUNT_W-1:0] mem_wd;
  logic [SLOTS-1:0]   exp_rest;

  assign accept     = cmd.in_ready && in_valid;
  assign arm_ok     = (tsu_mode_t'(mode) == MODE_ARM) && ({1'b0, slot_index} < SLOT_LIMIT);
  assign load_count = {1'b0, count_value} + COUNT_W'(1);
  assign dec_count  = rd_data - COUNT_W'(1);
  assign stg_update = stg_valid && stg_act;
  assign stg_expire = stg_update && (dec_count == '0);

  // one write port: arm/cancel on accept, decrement write-back during the walk
  always_comb begin
    mem_we = 1'b0;
    mem_wa = stg_idx;
    mem_wd = dec_count;
    if (accept && arm_ok) begin
      mem_we = 1'b1;
      mem_wa = slot_index[SLOT_W-1:0];
      mem_wd = arm_enable ? load_count : '0;
    end else if (stg_update) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_wa] <= mem_wd;
    end
    rd_data <= slot_mem[idx];
  end

  always_comb begin
    exp_rest      = exp_mask;
    exp_rest[idx] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count  <= '0;
      active_mask <= '0;
      exp_mask    <= '0;
      delay_count <= '0;
      idx         <= SLOT_TOP;
      stg_valid   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      stg_valid <= cmd.walk_issue;

      if (accept) begin
        exp_mask <= '0;
        idx      <= SLOT_TOP;
        unique case (tsu_mode_t'(mode))
          MODE_TICK: begin
            tick_count <= tick_count + TIME_W'(1);
            if (delay_count != '0) begin
              delay_count <= delay_count - COUNT_W'(1);
            end
          end
          MODE_ARM: begin
            if (arm_ok) begin
              active_mask[slot_index[SLOT_W-1:0]] <= arm_enable;
            end
          end
          MODE_DELAY: delay_count <= load_count;
          MODE_CLOCK: ;
          default: ;
        endcase
      end

      if (cmd.walk_issue || cmd.scan_step) begin
        idx <= idx - SLOT_W'(1);
      end
      if (cmd.idx_reload) begin
        idx <= SLOT_TOP;
      end

      if (stg_expire) begin
        active_mask[stg_idx] <= 1'b0;
        exp_mask[stg_idx]    <= 1'b1;
      end

      if (cmd.load_result) begin
        out_valid <= 1'b1;
        if (exp_mask[idx]) begin
          exp_mask <= exp_rest;
        end
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // walk stage and result payload
  always_ff @(posedge clk) begin
    if (cmd.walk_issue) begin
      stg_idx <= idx;
      stg_act <= active_mask[idx];
    end
    if (cmd.load_result) begin
      expired      <= exp_mask[idx];
      expired_slot <= exp_mask[idx] ? INDEX_W'(idx) : '0;
      last         <= exp_mask[idx] ? (exp_rest == '0) : 1'b1;
      time_now     <= tick_count;
      delay_busy   <= (delay_count != '0);
      active_slots <= MASK_W'(active_mask);
    end
  end

  assign status.in_valid  = in_valid;
  assign status.in_tick   = (tsu_mode_t'(mode) == MODE_TICK);
  assign status.idx_zero  = (idx == '0);
  assign status.exp_none  = (exp_mask == '0);
  assign status.exp_hit   = exp_mask[idx];
  assign status.out_taken = out_valid && out_ready;

endmodule

@@ rtl/multi_slot_tick_timeout_unit.sv @@
// Top level of the multi-slot tick timeout unit: stream ports, controller and datapath.
//
// A tick-driven timeout block with a 64-bit tick count, SLOTS one-shot slot
// counters (33 bits each, kept in a single-port-write memory) with an armed
// mask, and one delay countdown. Each input beat carries a mode in s_tuser:
// tick, arm/cancel a slot, start the delay, or read the clock. A tick bumps
// the time, steps the delay down, and walks every slot from the top index
// down through one shared decrementer, one slot per cycle, with a registered
// memory read stage; slots that reach zero are disarmed and reported, highest
// index first, one output beat each, the final one with m_tlast set. Any
// input that expires nothing yields one beat with m_tuser clear and m_tlast
// set. Status fields (time, delay busy, armed mask) on every beat show the
// state after the whole input. One item is handled at a time: a tick goes
// from accept through the slot walk and its end state to the expiry scan,
// which steps down the slot indices; each output beat then has a load and a
// handoff (held while m_tready is low), and other modes go from accept
// straight to the scan.
module multi_slot_tick_timeout_unit
  import tsu_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [39:0]  s_tdata,   // slot_index[4:0], count_value[36:5], arm_enable[37], 0
  input  logic [1:0]   s_tuser,   // mode[1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // expired_slot[4:0], time_now[68:5], delay_busy[69],
                                  // active_slots[101:70], 0
  output logic         m_tuser,   // expired[0]
  output logic         m_tlast    // last
);

  tsu_cmd_t    cmd;
  tsu_status_t status;

  logic [INDEX_W-1:0] expired_slot;
  logic [TIME_W-1:0]  time_now;
  logic               delay_busy;
  logic [MASK_W-1:0]  active_slots;

  tsu_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  tsu_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .in_valid     (s_tvalid),
    .mode         (s_tuser),
    .slot_index   (s_tdata[4:0]),
    .count_value  (s_tdata[36:5]),
    .arm_enable   (s_tdata[37]),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .expired      (m_tuser),
    .expired_slot (expired_slot),
    .last         (m_tlast),
    .time_now     (time_now),
    .delay_busy   (delay_busy),
    .active_slots (active_slots)
  );

  // input is taken only when the sequencer is idle
  assign s_tready = cmd.in_ready;

  // pack result beat, lowest field first, zero-filled to a byte boundary
  assign m_tdata = {2'b00, active_slots, delay_busy, time_now, expired_slot};

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the multi-slot tick timeout unit.
`timescale 1ns / 100ps

module tb;
  import tsu_pkg::*;

  // One expected output beat, fields as the block reports them.
  typedef struct {
    logic                 expired;
    logic [INDEX_W-1:0]   slot;
    logic                 last;
    logic [TIME_W-1:0]    time_now;
    logic                 delay_busy;
    logic [MASK_W-1:0]    armed;
  } tsu_beat_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [39:0]  s_tdata = '0;   // slot_index[4:0], count_value[36:5], arm_enable[37], 0
  logic [1:0]   s_tuser = '0;   // mode[1:0]
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;        // expired_slot[4:0], time_now[68:5], delay_busy[69],
                                // active_slots[101:70], 0
  logic         m_tuser;        // expired[0]
  logic         m_tlast;

  multi_slot_tick_timeout_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // Shadow state of the timer.
  logic [TIME_W-1:0]  ticks_seen;
  logic [MASK_W-1:0]  armed_mask;
  logic [COUNT_W-1:0] slot_left [SLOTS];
  logic [COUNT_W-1:0] delay_left;

  tsu_beat_t pending_beats [$];
  int        errors = 0;
  int        items_sent = 0;
  int        burst_left = 0;

  // Applies one accepted input to the shadow state and queues its beats.
  task automatic advance_timer(tsu_mode_t mode, logic [INDEX_W-1:0] slot,
                               logic [31:0] value, logic arm);
    int        hits [$];
    tsu_beat_t beat;
    hits = {};
    case (mode)
      MODE_TICK: begin
        ticks_seen = ticks_seen + 1'b1;
        for (int s = SLOTS - 1; s >= 0; s--) begin
          if (armed_mask[s]) begin
            slot_left[s] = slot_left[s] - 1'b1;
            if (slot_left[s] == '0) begin
              armed_mask[s] = 1'b0;
              hits.push_back(s);
            end
          end
        end
        if (delay_left != '0) delay_left = delay_left - 1'b1;
      end
      MODE_ARM: begin
        if (slot < SLOTS) begin
          if (arm) begin
            slot_left[slot]  = {1'b0, value} + 1'b1;
            armed_mask[slot] = 1'b1;
          end else begin
            slot_left[slot]  = '0;
            armed_mask[slot] = 1'b0;
          end
        end
      end
      MODE_DELAY: begin
        delay_left = {1'b0, value} + 1'b1;
      end
      default: ;
    endcase
    // status fields reflect the state after the whole input
    beat.time_now   = ticks_seen;
    beat.delay_busy = (delay_left != '0);
    beat.armed      = armed_mask;
    if (hits.size() == 0) begin
      beat.expired = 1'b0;
      beat.slot    = '0;
      beat.last    = 1'b1;
      pending_beats.push_back(beat);
    end else begin
      foreach (hits[k]) begin
        beat.expired = 1'b1;
        beat.slot    = INDEX_W'(hits[k]);
        beat.last    = (k == hits.size() - 1);
        pending_beats.push_back(beat);
      end
    end
  endtask

  // Sends one input beat; the sender runs in bursts with random gaps.
  task automatic send_item(tsu_mode_t mode, logic [INDEX_W-1:0] slot,
                           logic [31:0] value, logic arm);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 10);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {2'b00, arm, value, slot};
    do @(posedge clk); while (!s_tready);
    advance_timer(mode, slot, value, arm);
    burst_left--;
    items_sent++;
  endtask

  // Mostly short waits so that slots expire; now and then a full 32-bit count.
  function automatic logic [31:0] short_count();
    return ($urandom_range(0, 9) == 0) ? 32'($urandom) : 32'($urandom_range(0, 4));
  endfunction

  task automatic send_tick();
    send_item(MODE_TICK, INDEX_W'($urandom), 32'($urandom), 1'($urandom));
  endtask

  task automatic send_clock_read();
    send_item(MODE_CLOCK, INDEX_W'($urandom), 32'($urandom), 1'($urandom));
  endtask

  // Status-only inputs: reads, empty ticks, delay extremes, slot count extremes.
  task automatic test_status_modes();
    send_clock_read();
    send_tick();
    send_item(MODE_DELAY, 5'd0, 32'd0, 1'b0);
    send_tick();                                  // delay of zero ends on this tick
    send_item(MODE_DELAY, 5'd31, 32'hFFFF_FFFF, 1'b1);
    send_tick();
    send_item(MODE_ARM, 5'd31, 32'hFFFF_FFFF, 1'b1);
    send_item(MODE_ARM, 5'd31, 32'hFFFF_FFFF, 1'b0); // cancel of an armed slot
    send_clock_read();
  endtask

  // Several slots expire on one tick and come out highest index first.
  task automatic test_expiry_order();
    send_item(MODE_ARM, 5'd0,  32'd0, 1'b1);
    send_item(MODE_ARM, 5'd17, 32'd0, 1'b1);
    send_item(MODE_ARM, 5'd5,  32'd0, 1'b1);
    send_item(MODE_ARM, 5'd31, 32'd0, 1'b1);
    send_tick();
  endtask

  // Rearm overwrites the count; cancel stops a pending expiry.
  task automatic test_rearm_cancel();
    send_item(MODE_ARM, 5'd3, 32'd5, 1'b1);
    send_item(MODE_ARM, 5'd3, 32'd0, 1'b1);
    send_item(MODE_ARM, 5'd7, 32'd0, 1'b1);
    send_item(MODE_ARM, 5'd7, 32'd0, 1'b0);
    send_item(MODE_ARM, 5'd1, 32'd1, 1'b1);
    send_tick();                                  // slot 3 only
    send_tick();                                  // slot 1
  endtask

  // Every slot armed, then one tick expires all of them.
  task automatic test_all_slots_expire();
    int order [SLOTS];
    foreach (order[i]) order[i] = i;
    order.shuffle();
    foreach (order[i]) send_item(MODE_ARM, INDEX_W'(order[i]), 32'd0, 1'b1);
    send_tick();
  endtask

  task automatic arm_then_tick();
    int n_arm;
    int n_tick;
    n_arm  = $urandom_range(1, 6);
    n_tick = $urandom_range(1, 6);
    repeat (n_arm) send_item(MODE_ARM, INDEX_W'($urandom), short_count(), 1'b1);
    repeat (n_tick) begin
      if ($urandom_range(0, 5) == 0) send_clock_read();
      send_tick();
    end
  endtask

  task automatic test_random_traffic(int count);
    int stop_at;
    int pick;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 39);
      if (pick < 22) begin
        arm_then_tick();
      end else if (pick < 26) begin
        send_item(MODE_ARM, INDEX_W'($urandom), 32'($urandom), 1'b0);
        if ($urandom_range(0, 1) == 1) send_tick();
      end else if (pick < 30) begin
        send_item(MODE_DELAY, INDEX_W'($urandom), short_count(), 1'($urandom));
        repeat ($urandom_range(0, 3)) send_tick();
      end else if (pick < 33) begin
        send_clock_read();
      end else if (pick < 39) begin
        // noise: any mode, any fields
        send_item(tsu_mode_t'($urandom_range(0, 3)), INDEX_W'($urandom),
                  32'($urandom), 1'($urandom));
      end else begin
        test_all_slots_expire();
      end
    end
  endtask

  // Receiver stalls: runs of always-ready, coin-flip and mostly-stalled.
  int stall_style = 0;
  int stall_left  = 0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_style <= $urandom_range(0, 2);
      stall_left  <= $urandom_range(20, 100);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_style)
      0:       m_tready <= 1'b1;
      1:       m_tready <= 1'($urandom_range(0, 1));
      default: m_tready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    tsu_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual %0h/%0h/%0h", $time,
                 m_tuser, m_tlast, m_tdata);
        errors++;
      end else begin
        want = pending_beats.pop_front();
        check_field("expired",      want.expired,    m_tuser);
        check_field("expired_slot", want.slot,       m_tdata[4:0]);
        check_field("last",         want.last,       m_tlast);
        check_field("time_now",     want.time_now,   m_tdata[68:5]);
        check_field("delay_busy",   want.delay_busy, m_tdata[69]);
        check_field("active_slots", want.armed,      m_tdata[101:70]);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    ticks_seen = '0;
    armed_mask = '0;
    delay_left = '0;
    foreach (slot_left[i]) slot_left[i] = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_status_modes();
    test_expiry_order();
    test_rearm_cancel();
    test_all_slots_expire();
    test_random_traffic(150);

    s_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);   // catch stray beats after the last one
    if (errors == 0 && pending_beats.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
